/* hw/rtl/softmax_rank_select_macros.svh */
// assertion macros for the softmax rank select block
// no dependencies; taken in by files that carry concurrent checks
`ifndef SOFTMAX_RANK_SELECT_MACROS_SVH
`define SOFTMAX_RANK_SELECT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge out of reset
`define SRS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error("srs check failed");
// condition must never be seen out of reset
`define SRS_ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error("srs bad state");
`else
`define SRS_ASSERT(lbl, clk, rstn, prop)
`define SRS_ASSERT_NEVER(lbl, clk, rstn, cond)
`endif
`endif

/* hw/rtl/srs_pkg.sv */
// shared types and constants of the softmax rank select block
// no dependencies
`timescale 1ns / 1ps
package srs_pkg;

  localparam int unsigned MaxDrives   = 16;
  localparam int unsigned Slots       = 16;
  localparam int unsigned IndexW      = 4;
  localparam int unsigned DivDvdW     = 64;
  localparam int unsigned DivDsrW     = 32;
  localparam int unsigned SeriesTerms = 10;
  localparam logic [31:0] Ln2Q30      = 32'd744261118;
  localparam logic [30:0] TFloor      = 31'd17;
  localparam logic [31:0] OneQ24      = 32'd16777216;
  localparam logic [55:0] XLimitQ24   = 56'd18 << 24;

  typedef enum logic [1:0] {
    CFG_SOFTMAX_EN = 2'd0,
    CFG_TEMP       = 2'd1,
    CFG_MIN_VALID  = 2'd2
  } cfg_reg_e;

  typedef enum logic [1:0] {
    RANK_NONE  = 2'd0,
    RANK_VALID = 2'd1,
    RANK_LOW   = 2'd2
  } rank_e;

  typedef struct packed {
    logic signed [31:0] cand_logit;
    logic               cand_active;
    logic               last_cand;
  } in_beat_t;

  typedef struct packed {
    logic [IndexW-1:0]  cand_index;
    logic signed [31:0] cand_score;
    rank_e              rank_status;
    logic               overflow_seen;
    logic               last_out;
  } out_beat_t;

  typedef struct packed {
    logic               start;
    logic [DivDvdW-1:0] dividend;
    logic [DivDsrW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [DivDvdW-1:0] quot;
  } div_rsp_t;

endpackage

/* hw/rtl/srs_div.sv */
// shared restoring divider, one quotient bit per cycle
// depends on srs_pkg
`timescale 1ns / 1ps
module srs_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  srs_pkg::div_req_t   req_i,
  output srs_pkg::div_rsp_t   rsp_o
);

  localparam int unsigned DW   = srs_pkg::DivDvdW;
  localparam int unsigned RW   = srs_pkg::DivDsrW;
  localparam int unsigned CntW = $clog2(DW);

  logic            busy_q, busy_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [DW-1:0]   dvd_q, dvd_d;
  logic [RW-1:0]   rem_q, rem_d;
  logic [RW-1:0]   dsr_q, dsr_d;
  logic            done_q, done_d;
  logic [RW:0]     trial;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    done_d = 1'b0;
    trial  = {rem_q, dvd_q[DW-1]};
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '1;
      dvd_d  = req_i.dividend;
      dsr_d  = req_i.divisor;
      rem_d  = '0;
    end else if (busy_q) begin
      // quotient bits shift in where dividend bits leave
      if (trial >= {1'b0, dsr_q}) begin
        rem_d = RW'(trial - {1'b0, dsr_q});
        dvd_d = {dvd_q[DW-2:0], 1'b1};
      end else begin
        rem_d = trial[RW-1:0];
        dvd_d = {dvd_q[DW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = dvd_q;

endmodule

/* hw/rtl/softmax_rank_select.sv */
// softmax rank select top level: candidate store, sequencer, output register
// depends on srs_pkg, srs_div and softmax_rank_select_macros.svh
`timescale 1ns / 1ps
`include "softmax_rank_select_macros.svh"
// usage
//  - input channel in_valid_i / in_stall_o carries one candidate per beat
//    (logit, active flag, last flag); while loading one beat per cycle is taken
//  - up to min(MAX_DRIVES, 16) candidates are kept; extra beats are dropped
//    and set overflow_seen in every result of the set
//  - a beat with last_cand closes the set; in_stall_o then stays high until
//    the last result of the set has been loaded into the output register
//  - softmax mode: a scan pass runs each active candidate through the shared
//    divider for gap / T, a subtract loop for the ln2 reduction (k at most 25)
//    and ten series steps (S_MUL, S_TGO, S_TDIV) on the shared multiplier;
//    a term that underflows skips the loop and the series, and inactive
//    candidates are passed over
//  - each softmax result of an active candidate then runs through S_PREP, a
//    divide in S_PDIV and S_EMIT
//  - pass-through mode or inactive candidates: S_PREP then S_EMIT per result
//  - output channel out_valid_o / out_stall_i is one register deep; a stalled
//    beat holds, and the sequencer waits until it is taken
//  - config writes (cfg_we_i) must be made only when idle; not enforced
//  - reset: softmax on, temperature 1.0, minimum 0, empty set, no output
module softmax_rank_select #(
  parameter int unsigned MAX_DRIVES = srs_pkg::MaxDrives
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_idx_i,
  input  logic [31:0]          cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  srs_pkg::in_beat_t    in_beat_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output srs_pkg::out_beat_t   out_beat_o
);

  localparam int unsigned Cap  = (MAX_DRIVES < srs_pkg::Slots) ? MAX_DRIVES : srs_pkg::Slots;
  localparam int unsigned CntW = $clog2(Cap + 1);
  localparam int unsigned AW   = (Cap > 1) ? $clog2(Cap) : 1;

  typedef enum logic [10:0] {
    S_LOAD = 11'b000_0000_0001,
    S_SCAN = 11'b000_0000_0010,
    S_XDIV = 11'b000_0000_0100,
    S_KDIV = 11'b000_0000_1000,
    S_MUL  = 11'b000_0001_0000,
    S_TGO  = 11'b000_0010_0000,
    S_TDIV = 11'b000_0100_0000,
    S_ACC  = 11'b000_1000_0000,
    S_PREP = 11'b001_0000_0000,
    S_PDIV = 11'b010_0000_0000,
    S_EMIT = 11'b100_0000_0000
  } state_e;

  // configuration
  logic               smx_en_q;
  logic [30:0]        temp_q;
  logic signed [31:0] min_q;

  // set state
  state_e             state_q, state_d;
  logic [CntW-1:0]    load_cnt_q, load_cnt_d;
  logic [CntW-1:0]    act_cnt_q, act_cnt_d;
  logic [CntW-1:0]    i_q, i_d;
  logic signed [31:0] max_q, max_d;
  logic               ovf_q, ovf_d;
  logic [31:0]        exp_sum_q, exp_sum_d;

  // exp term working registers
  logic [34:0]        x30_q, x30_d;
  logic [4:0]         k_q, k_d;
  logic [29:0]        r_q, r_d;
  logic [30:0]        term_q, term_d;
  logic [32:0]        ser_q, ser_d;
  logic [3:0]         ord_q, ord_d;
  logic [64:0]        prod_q, prod_d;
  logic [31:0]        score_q, score_d;

  // candidate store
  logic signed [31:0] logit_mem [Cap];
  logic               act_mem   [Cap];
  logic [24:0]        e_mem     [Cap];
  logic               ld_we, e_we;
  logic [24:0]        e_wdata;

  srs_pkg::out_beat_t out_q, out_d;
  logic               out_valid_q, out_valid_d;

  srs_pkg::div_req_t  div_req;
  srs_pkg::div_rsp_t  div_rsp;

  // shared multiplier: series products and reciprocal division by the order
  logic [30:0]        mul_a;
  logic [33:0]        mul_b;
  logic [64:0]        mul_p;

  logic               in_acc;
  logic [AW-1:0]      rd_idx, wr_idx;
  logic signed [31:0] rd_logit;
  logic               rd_act;
  logic [24:0]        rd_e;
  logic [31:0]        gap;
  logic [30:0]        t_eff;
  logic [5:0]         sh;
  logic [32:0]        e_full;
  logic               out_free;
  logic signed [31:0] score_sel;

  // ceil(2^33 / ord); exact floor division for dividends below 2^30
  function automatic logic [33:0] recip_q33(input logic [3:0] ord);
    logic [33:0] m;
    case (ord)
      4'd1:    m = 34'd8589934592;
      4'd2:    m = 34'd4294967296;
      4'd3:    m = 34'd2863311531;
      4'd4:    m = 34'd2147483648;
      4'd5:    m = 34'd1717986919;
      4'd6:    m = 34'd1431655766;
      4'd7:    m = 34'd1227133514;
      4'd8:    m = 34'd1073741824;
      4'd9:    m = 34'd954437177;
      4'd10:   m = 34'd858993460;
      default: m = '0;
    endcase
    return m;
  endfunction

  srs_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign in_stall_o = (state_q != S_LOAD);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign rd_idx     = i_q[AW-1:0];
  assign wr_idx     = load_cnt_q[AW-1:0];
  assign rd_logit   = logit_mem[rd_idx];
  assign rd_act     = act_mem[rd_idx];
  assign rd_e       = e_mem[rd_idx];
  // gap of an active candidate to the largest active logit is never negative
  assign gap        = 32'($signed({max_q[31], max_q}) - $signed({rd_logit[31], rd_logit}));
  assign t_eff      = (temp_q < srs_pkg::TFloor) ? srs_pkg::TFloor : temp_q;
  // round half up, scale by 2^-(k+6) to land in Q8.24
  assign sh         = {1'b0, k_q} + 6'd6;
  assign e_full     = (ser_q + (33'd1 << (sh - 6'd1))) >> sh;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign mul_p      = {34'd0, mul_a} * {31'd0, mul_b};

  always_comb begin
    state_d    = state_q;
    load_cnt_d = load_cnt_q;
    act_cnt_d  = act_cnt_q;
    i_d        = i_q;
    max_d      = max_q;
    ovf_d      = ovf_q;
    exp_sum_d  = exp_sum_q;
    x30_d      = x30_q;
    k_d        = k_q;
    r_d        = r_q;
    term_d     = term_q;
    ser_d      = ser_q;
    ord_d      = ord_q;
    prod_d     = prod_q;
    score_d    = score_q;
    out_d      = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    ld_we      = 1'b0;
    e_we       = 1'b0;
    e_wdata    = '0;
    div_req    = '0;
    mul_a      = '0;
    mul_b      = '0;
    score_sel  = rd_act ? rd_logit : 32'sd0;

    unique case (state_q)
      S_LOAD: begin
        if (in_acc) begin
          if (load_cnt_q < CntW'(Cap)) begin
            ld_we      = 1'b1;
            load_cnt_d = load_cnt_q + 1'b1;
            if (in_beat_i.cand_active) begin
              act_cnt_d = act_cnt_q + 1'b1;
              if (in_beat_i.cand_logit > max_q) begin
                max_d = in_beat_i.cand_logit;
              end
            end
          end else begin
            ovf_d = 1'b1;
          end
          if (in_beat_i.last_cand) begin
            i_d     = '0;
            state_d = smx_en_q ? S_SCAN : S_PREP;
          end
        end
      end
      S_SCAN: begin
        if (i_q == load_cnt_q) begin
          i_d     = '0;
          state_d = S_PREP;
        end else if (rd_act) begin
          div_req.start    = 1'b1;
          div_req.dividend = {8'd0, gap, 24'd0};
          div_req.divisor  = {1'b0, t_eff};
          state_d          = S_XDIV;
        end else begin
          i_d = i_q + 1'b1;
        end
      end
      S_XDIV: begin
        if (div_rsp.done) begin
          if (div_rsp.quot >= {8'd0, srs_pkg::XLimitQ24}) begin
            // term underflows to zero
            e_we    = 1'b1;
            e_wdata = '0;
            i_d     = i_q + 1'b1;
            state_d = S_SCAN;
          end else begin
            x30_d   = {div_rsp.quot[28:0], 6'd0};
            k_d     = '0;
            state_d = S_KDIV;
          end
        end
      end
      S_KDIV: begin
        // peel off one ln2 per cycle, what is left is r
        if (x30_q >= {3'd0, srs_pkg::Ln2Q30}) begin
          x30_d = x30_q - {3'd0, srs_pkg::Ln2Q30};
          k_d   = k_q + 5'd1;
        end else begin
          r_d     = x30_q[29:0];
          term_d  = 31'd1 << 30;
          ser_d   = 33'd1 << 30;
          ord_d   = 4'd1;
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        mul_a   = term_q;
        mul_b   = {4'd0, r_q};
        prod_d  = mul_p;
        state_d = S_TGO;
      end
      S_TGO: begin
        mul_a   = {1'b0, prod_q[59:30]};
        mul_b   = recip_q33(ord_q);
        prod_d  = mul_p;
        state_d = S_TDIV;
      end
      S_TDIV: begin
        term_d = {1'b0, prod_q[62:33]};
        // alternating series of exp(-r)
        if (ord_q[0]) begin
          ser_d = ser_q - {3'd0, prod_q[62:33]};
        end else begin
          ser_d = ser_q + {3'd0, prod_q[62:33]};
        end
        if (ord_q == 4'(srs_pkg::SeriesTerms)) begin
          state_d = S_ACC;
        end else begin
          ord_d   = ord_q + 4'd1;
          state_d = S_MUL;
        end
      end
      S_ACC: begin
        e_we      = 1'b1;
        e_wdata   = e_full[24:0];
        exp_sum_d = exp_sum_q + {7'd0, e_full[24:0]};
        i_d       = i_q + 1'b1;
        state_d   = S_SCAN;
      end
      S_PREP: begin
        if (rd_act && smx_en_q) begin
          div_req.start = 1'b1;
          if (exp_sum_q == '0) begin
            div_req.dividend = {32'd0, srs_pkg::OneQ24};
            div_req.divisor  = 32'(act_cnt_q);
          end else begin
            div_req.dividend = {15'd0, rd_e, 24'd0} + {33'd0, exp_sum_q[31:1]};
            div_req.divisor  = exp_sum_q;
          end
          state_d = S_PDIV;
        end else begin
          score_d = score_sel;
          state_d = S_EMIT;
        end
      end
      S_PDIV: begin
        if (div_rsp.done) begin
          score_d = div_rsp.quot[31:0];
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_d           = 1'b1;
          out_d.cand_index      = srs_pkg::IndexW'(i_q);
          out_d.cand_score      = score_q;
          out_d.overflow_seen   = ovf_q;
          out_d.last_out        = (i_q + 1'b1 == load_cnt_q);
          if (!rd_act) begin
            out_d.rank_status = srs_pkg::RANK_NONE;
          end else if ($signed(score_q) >= min_q) begin
            out_d.rank_status = srs_pkg::RANK_VALID;
          end else begin
            out_d.rank_status = srs_pkg::RANK_LOW;
          end
          if (i_q + 1'b1 == load_cnt_q) begin
            // set done, back to an empty store
            load_cnt_d = '0;
            act_cnt_d  = '0;
            max_d      = 32'sh8000_0000;
            ovf_d      = 1'b0;
            exp_sum_d  = '0;
            state_d    = S_LOAD;
          end else begin
            i_d     = i_q + 1'b1;
            state_d = S_PREP;
          end
        end
      end
      default: state_d = S_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smx_en_q    <= 1'b1;
      temp_q      <= 31'(srs_pkg::OneQ24);
      min_q       <= '0;
      state_q     <= S_LOAD;
      load_cnt_q  <= '0;
      act_cnt_q   <= '0;
      i_q         <= '0;
      max_q       <= 32'sh8000_0000;
      ovf_q       <= 1'b0;
      exp_sum_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          srs_pkg::CFG_SOFTMAX_EN: smx_en_q <= cfg_wdata_i[0];
          srs_pkg::CFG_TEMP:       temp_q   <= cfg_wdata_i[30:0];
          srs_pkg::CFG_MIN_VALID:  min_q    <= cfg_wdata_i;
          default: ;
        endcase
      end
      state_q     <= state_d;
      load_cnt_q  <= load_cnt_d;
      act_cnt_q   <= act_cnt_d;
      i_q         <= i_d;
      max_q       <= max_d;
      ovf_q       <= ovf_d;
      exp_sum_q   <= exp_sum_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x30_q   <= x30_d;
    k_q     <= k_d;
    r_q     <= r_d;
    term_q  <= term_d;
    ser_q   <= ser_d;
    ord_q   <= ord_d;
    prod_q  <= prod_d;
    score_q <= score_d;
    out_q   <= out_d;
    if (ld_we) begin
      logit_mem[wr_idx] <= in_beat_i.cand_logit;
      act_mem[wr_idx]   <= in_beat_i.cand_active;
    end
    if (e_we) begin
      e_mem[rd_idx] <= e_wdata;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;

  `SRS_ASSERT_NEVER(a_load_cap, clk_i, rst_ni, load_cnt_q > CntW'(Cap))
  `SRS_ASSERT_NEVER(a_act_le_load, clk_i, rst_ni, act_cnt_q > load_cnt_q)
  `SRS_ASSERT_NEVER(a_sum_bound, clk_i, rst_ni, exp_sum_q > (32'(Cap) << 24))
  `SRS_ASSERT(a_last_frees, clk_i, rst_ni, (state_q == S_EMIT && out_free && out_d.last_out) |=> (state_q == S_LOAD && load_cnt_q == '0))

endmodule

/* test/softmax_rank_select_tb.sv */
// self-checking testbench of the softmax rank select block
// depends on srs_pkg and softmax_rank_select; drives candidate sets, predicts every result beat
`timescale 1ns / 1ps
module softmax_rank_select_tb;

  localparam int unsigned Capacity =
    (srs_pkg::MaxDrives < srs_pkg::Slots) ? srs_pkg::MaxDrives : srs_pkg::Slots;
  // slowest sets are full softmax sets; the limit allows for many of them
  localparam longint CycleLimit = 64'd3000000;
  localparam logic [1:0] CfgUnusedIdx = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_idx = '0;
  logic [31:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  srs_pkg::in_beat_t in_beat = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  srs_pkg::out_beat_t out_beat;

  softmax_rank_select uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_beat_i  (in_beat),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_beat_o (out_beat)
  );

  always #1 clk = ~clk;

  // idling percentages of the two sides, changed per phase
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  longint cycles = 0;
  int errors = 0;
  int n_sets = 0;
  int n_results = 0;

  // shadow of the config registers
  logic softmax_on = 1'b1;
  logic [30:0] temp_q24 = 31'd16777216;
  logic signed [31:0] min_valid = '0;

  // shadow of the candidate set being loaded
  logic signed [31:0] logits [srs_pkg::Slots];
  logic active [srs_pkg::Slots];
  int unsigned n_loaded = 0;
  int unsigned n_active = 0;
  logic signed [31:0] top_logit = 32'sh8000_0000;
  logic dropped = 1'b0;

  srs_pkg::out_beat_t expected_scores [$];

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("[softmax_rank_select] ERROR");
      $finish;
    end
  end

  // receiver stall, random per cycle
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // exp(-gap/T) in Q8.24 with a truncated Taylor series on the reduced argument
  function automatic logic [63:0] exp_weight(input logic [63:0] gap);
    logic [63:0] t, x, x30, k, r, term, acc;
    t = (temp_q24 < srs_pkg::TFloor) ? 64'(srs_pkg::TFloor) : 64'(temp_q24);
    x = (gap << 24) / t;
    if (x >= 64'(srs_pkg::XLimitQ24)) return 64'd0;
    x30 = x << 6;
    k = x30 / 64'(srs_pkg::Ln2Q30);
    r = x30 - k * 64'(srs_pkg::Ln2Q30);
    term = 64'd1 << 30;
    acc = term;
    for (int i = 1; i <= srs_pkg::SeriesTerms; i++) begin
      term = ((term * r) >> 30) / 64'(i);
      if (i % 2 == 1) acc = acc - term;
      else acc = acc + term;
    end
    return (acc + (64'd1 << (k + 5))) >> (k + 6);
  endfunction

  // load one accepted candidate; on the closing beat queue the whole set
  task automatic load_candidate(input srs_pkg::in_beat_t b);
    logic [63:0] wsum, e;
    longint score;
    srs_pkg::out_beat_t r;
    if (n_loaded < Capacity) begin
      logits[n_loaded] = b.cand_logit;
      active[n_loaded] = b.cand_active;
      if (b.cand_active) begin
        if (b.cand_logit > top_logit) top_logit = b.cand_logit;
        n_active++;
      end
      n_loaded++;
    end else begin
      dropped = 1'b1;
    end
    if (!b.last_cand) return;
    wsum = '0;
    if (softmax_on && n_active > 0) begin
      for (int i = 0; i < n_loaded; i++)
        if (active[i]) wsum += exp_weight(64'(longint'(top_logit) - longint'(logits[i])));
    end
    for (int i = 0; i < n_loaded; i++) begin
      score = 0;
      r.rank_status = srs_pkg::RANK_NONE;
      if (active[i]) begin
        if (!softmax_on) begin
          score = logits[i];
        end else if (wsum == 0) begin
          score = longint'(srs_pkg::OneQ24) / n_active;
        end else begin
          e = exp_weight(64'(longint'(top_logit) - longint'(logits[i])));
          score = longint'(((e << 24) + wsum / 2) / wsum);
        end
        r.rank_status = (score >= longint'(min_valid)) ? srs_pkg::RANK_VALID
                                                       : srs_pkg::RANK_LOW;
      end
      r.cand_index = i[srs_pkg::IndexW-1:0];
      r.cand_score = score[31:0];
      r.overflow_seen = dropped;
      r.last_out = (i + 1 == n_loaded);
      expected_scores.push_back(r);
    end
    n_sets++;
    n_loaded = 0;
    n_active = 0;
    top_logit = 32'sh8000_0000;
    dropped = 1'b0;
  endtask

  // result checker; stall is stable from negedge to the accepting edge
  always @(negedge clk) begin
    srs_pkg::out_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      n_results++;
      if (expected_scores.size() == 0) begin
        $display("%0t unexpected result beat %p", $time, out_beat);
        errors++;
      end else begin
        want = expected_scores.pop_front();
        if (out_beat.cand_index !== want.cand_index) begin
          $display("%0t cand_index exp %0d got %0d", $time, want.cand_index,
                   out_beat.cand_index);
          errors++;
        end
        if (out_beat.cand_score !== want.cand_score) begin
          $display("%0t cand_score exp %0d got %0d (index %0d)", $time, want.cand_score,
                   out_beat.cand_score, want.cand_index);
          errors++;
        end
        if (out_beat.rank_status !== want.rank_status) begin
          $display("%0t rank_status exp %0d got %0d", $time, want.rank_status,
                   out_beat.rank_status);
          errors++;
        end
        if (out_beat.overflow_seen !== want.overflow_seen) begin
          $display("%0t overflow_seen exp %0b got %0b", $time, want.overflow_seen,
                   out_beat.overflow_seen);
          errors++;
        end
        if (out_beat.last_out !== want.last_out) begin
          $display("%0t last_out exp %0b got %0b", $time, want.last_out,
                   out_beat.last_out);
          errors++;
        end
      end
    end
  end

  // send one candidate beat, with random sender idling before it
  task automatic send_candidate(input logic signed [31:0] logit, input logic act,
                                input logic last);
    srs_pkg::in_beat_t b;
    logic taken;
    b.cand_logit = logit;
    b.cand_active = act;
    b.last_cand = last;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_beat <= b;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    load_candidate(b);
  endtask

  task automatic end_stream();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // wait for every queued result, then let the sequencer settle
  task automatic drain();
    end_stream();
    while (expected_scores.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [1:0] idx, input logic [31:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      srs_pkg::CFG_SOFTMAX_EN: softmax_on = data[0];
      srs_pkg::CFG_TEMP:       temp_q24 = data[30:0];
      srs_pkg::CFG_MIN_VALID:  min_valid = data;
      default: ;
    endcase
  endtask

  // directed corners: extremes, inactive sets, clamp, overflow with dropped last
  task automatic test_directed();
    send_candidate(32'sd0, 1'b1, 1'b1);
    send_candidate(32'sh8000_0000, 1'b1, 1'b0);
    send_candidate(32'sh7fff_ffff, 1'b1, 1'b1);
    send_candidate(32'sd5, 1'b0, 1'b0);
    send_candidate(-32'sd5, 1'b0, 1'b1);
    send_candidate(32'sd1 <<< 24, 1'b1, 1'b0);
    send_candidate(32'sd1 <<< 24, 1'b1, 1'b0);
    send_candidate(32'sd0, 1'b1, 1'b1);
    drain();
    write_cfg(srs_pkg::CFG_TEMP, 32'd0);
    write_cfg(CfgUnusedIdx, 32'hffff_ffff);
    send_candidate(32'sd0, 1'b1, 1'b0);
    send_candidate(-32'sd100, 1'b1, 1'b1);
    drain();
    write_cfg(srs_pkg::CFG_TEMP, 32'h7fff_ffff);
    write_cfg(srs_pkg::CFG_MIN_VALID, 32'd4194304);
    send_candidate(32'sh8000_0000, 1'b1, 1'b0);
    send_candidate(32'sh7fff_ffff, 1'b1, 1'b1);
    drain();
    write_cfg(srs_pkg::CFG_SOFTMAX_EN, 32'd0);
    write_cfg(srs_pkg::CFG_MIN_VALID, 32'h8000_0000);
    for (int i = 0; i < Capacity + 1; i++)
      send_candidate($urandom, 1'($urandom_range(1)), i == Capacity);
    drain();
    write_cfg(srs_pkg::CFG_MIN_VALID, 32'h7fff_ffff);
    send_candidate(32'sh7fff_ffff, 1'b1, 1'b0);
    send_candidate(32'sh8000_0000, 1'b1, 1'b1);
    drain();
  endtask

  function automatic logic [31:0] pick_temp();
    case ($urandom_range(5))
      0: return 32'd0;
      1: return 32'd17;
      2: return 32'h7fff_ffff;
      3: return 32'd16777216;
      default: return $urandom_range(32'h0400_0000, 32'h0001_0000);
    endcase
  endfunction

  // random sets, mostly small and softmax with nearby logits
  task automatic test_random_sets(input int n_items);
    int sent, size;
    logic signed [31:0] base, lg;
    write_cfg(srs_pkg::CFG_SOFTMAX_EN, 32'($urandom_range(3) != 0));
    write_cfg(srs_pkg::CFG_TEMP, pick_temp());
    case ($urandom_range(3))
      0: write_cfg(srs_pkg::CFG_MIN_VALID, 32'd0);
      1: write_cfg(srs_pkg::CFG_MIN_VALID, $urandom);
      default: write_cfg(srs_pkg::CFG_MIN_VALID, $urandom_range(32'd16777216));
    endcase
    sent = 0;
    while (sent < n_items) begin
      case ($urandom_range(19))
        0: size = $urandom_range(Capacity + 3, Capacity + 1);
        1, 2: size = $urandom_range(Capacity, 8);
        default: size = $urandom_range(5, 1);
      endcase
      base = $urandom;
      for (int i = 0; i < size; i++) begin
        if ($urandom_range(3) == 0) lg = $urandom;
        else lg = base + $signed($urandom_range(32'h0800_0000)) - 32'sh0400_0000;
        send_candidate(lg, ($urandom_range(4) != 0), i == size - 1);
      end
      sent += size;
    end
    drain();
  endtask

  task automatic test_idle_phases();
    send_idle_pct = 30;
    recv_idle_pct = 77;
    test_random_sets(40);
    test_random_sets(40);
    send_idle_pct = 77;
    recv_idle_pct = 30;
    test_random_sets(40);
    test_random_sets(40);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_sets(45);
    test_random_sets(45);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_idle_phases();
    $display("covered %0d candidate sets and %0d result beats", n_sets, n_results);
    $display("softmax and pass-through, clamped and extreme temperature, overflow, stalls");
    if (errors == 0) begin
      $display("[softmax_rank_select] OK");
    end else begin
      $display("[softmax_rank_select] ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/srs_pkg.sv
hw/rtl/srs_div.sv
hw/rtl/softmax_rank_select.sv
test/softmax_rank_select_tb.sv
